// ----- rtl/bssc_pkg.sv -----
package bssc_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int DUTY_BITS_DEF   = 9;

    // Fixed field widths
    localparam int HALL_W    = 3;
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Register reset values
    localparam int PEDAL_IDLE_RST     = 1250;
    localparam int PEDAL_MAX_RST      = 3363;
    localparam int DUTY_LIMIT_RST     = 408;
    localparam int DUTY_THRESHOLD_RST = 5;
    localparam int ARM_THRESHOLD_RST  = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEDAL_IDLE     = 3'd0,
        CFG_PEDAL_MAX      = 3'd1,
        CFG_DUTY_LIMIT     = 3'd2,
        CFG_DUTY_THRESHOLD = 3'd3,
        CFG_ARM_THRESHOLD  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_C
    } t_phase;

    // Datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIFF,
        OP_MUL,
        OP_DIV,
        OP_CLAMP,
        OP_EMIT
    } t_op;

    // Handshake a step waits on before it fires
    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_wait;

    localparam int USTEP_W = 3;
    typedef logic [USTEP_W-1:0] t_ustep;

    localparam t_ustep US_FETCH = 3'd0;
    localparam t_ustep US_DIFF  = 3'd1;
    localparam t_ustep US_MUL   = 3'd2;
    localparam t_ustep US_DIV   = 3'd3;
    localparam t_ustep US_CLAMP = 3'd4;
    localparam t_ustep US_EMIT  = 3'd5;

    typedef struct packed {
        t_op    op;
        t_wait  wt;
        logic   loop;   // repeat this step while the loop count is nonzero
        t_ustep nxt;
    } t_uword;

    // Control store
    function automatic t_uword ucode(input t_ustep s);
        t_uword w;
        case (s)
            US_FETCH: w = '{op: OP_LOAD,  wt: W_IN,   loop: 1'b0, nxt: US_DIFF};
            US_DIFF:  w = '{op: OP_DIFF,  wt: W_NONE, loop: 1'b0, nxt: US_MUL};
            US_MUL:   w = '{op: OP_MUL,   wt: W_NONE, loop: 1'b0, nxt: US_DIV};
            US_DIV:   w = '{op: OP_DIV,   wt: W_NONE, loop: 1'b1, nxt: US_CLAMP};
            US_CLAMP: w = '{op: OP_CLAMP, wt: W_NONE, loop: 1'b0, nxt: US_EMIT};
            US_EMIT:  w = '{op: OP_EMIT,  wt: W_OUT,  loop: 1'b0, nxt: US_FETCH};
            default:  w = '{op: OP_NOP,   wt: W_NONE, loop: 1'b0, nxt: US_FETCH};
        endcase
        return w;
    endfunction

    // Hall code to commutation step, 0 for an invalid code
    function automatic logic [STEP_W-1:0] hall_step(input logic [HALL_W-1:0] hall);
        logic [STEP_W-1:0] s;
        case (hall)
            3'd5:    s = 3'd1;
            3'd1:    s = 3'd2;
            3'd3:    s = 3'd3;
            3'd2:    s = 3'd4;
            3'd6:    s = 3'd5;
            3'd4:    s = 3'd6;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic t_phase pwm_phase(input logic [STEP_W-1:0] s);
        t_phase p;
        case (s)
            3'd1:    p = PH_B;
            3'd2:    p = PH_C;
            3'd3:    p = PH_C;
            3'd4:    p = PH_A;
            3'd5:    p = PH_A;
            3'd6:    p = PH_B;
            default: p = PH_A;
        endcase
        return p;
    endfunction

    function automatic t_phase low_phase(input logic [STEP_W-1:0] s);
        t_phase p;
        case (s)
            3'd1:    p = PH_A;
            3'd2:    p = PH_A;
            3'd3:    p = PH_B;
            3'd4:    p = PH_B;
            3'd5:    p = PH_C;
            3'd6:    p = PH_C;
            default: p = PH_A;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/bldc_six_step_commutator_unit.sv -----
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+-------------------------------------------------
// s_       | in  | s_tvalid/s_tready  | s_tdata: hall_code, pedal_sample
// m_       | out | m_tvalid/m_tready  | m_tdata: phase A/B/C on+duty, step, duty, armed
// i_cfg_   | in  | i_cfg_we           | i_cfg_idx, i_cfg_data (write only)
//
// An item occupies the sequencer through its steps in order:
// load, difference, multiply, DUTY_BITS divide steps, clamp, emit. The result
// register loads on the emit step, and the next input transfer can follow once
// the emit step has fired. A stalled m_tready holds the emit step.
// Reset (i_rst_n low, synchronous) clears the sequencer, the output valid and
// the interlock, and loads the register reset values.
module bldc_six_step_commutator_unit #(
    parameter int SAMPLE_BITS = bssc_pkg::SAMPLE_BITS_DEF,
    parameter int DUTY_BITS   = bssc_pkg::DUTY_BITS_DEF,
    localparam int IN_W  = ((bssc_pkg::HALL_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((4 * DUTY_BITS + 7 + 7) / 8) * 8,
    localparam int CFG_W = (SAMPLE_BITS > DUTY_BITS) ? SAMPLE_BITS : DUTY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // hall_code, pedal_sample
    input  logic [IN_W-1:0]                s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // phase_a_on, phase_a_duty, phase_b_on, phase_b_duty, phase_c_on,
    // phase_c_duty, step_number, mapped_duty, armed
    output logic [OUT_W-1:0]               m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           i_cfg_we,
    input  logic [bssc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]               i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int DB    = DUTY_BITS;
    localparam int CNT_W = $clog2(DB);
    localparam int HW    = bssc_pkg::HALL_W;
    localparam int SW    = bssc_pkg::STEP_W;

    // Configuration registers
    logic [SB-1:0] r_pedal_idle;
    logic [SB-1:0] r_pedal_max;
    logic [DB-1:0] r_duty_limit;
    logic [DB-1:0] r_duty_thr;
    logic [DB-1:0] r_arm_thr;

    // Sequencer
    bssc_pkg::t_ustep r_step;
    bssc_pkg::t_ustep n_step;
    bssc_pkg::t_uword uw;
    logic             fire;
    logic             out_free;
    logic [CNT_W-1:0] r_cnt;

    // Datapath
    logic [SB-1:0]    r_sample;
    logic [SW-1:0]    r_step_no;
    logic [SB-1:0]    r_a;
    logic [SB-1:0]    r_d;
    logic             r_zero;
    logic             r_sat;
    logic [SB-1:0]    r_rem;
    logic [DB-1:0]    r_num;
    logic [DB-1:0]    r_q;
    logic [DB-1:0]    r_duty;
    logic             r_armed;

    logic [SB:0]      diff;
    logic [SB:0]      den;
    logic [SB-1:0]    diff_abs;
    logic [SB-1:0]    den_abs;
    logic [SB+DB-1:0] prod;
    logic [SB:0]      trial;
    logic             trial_ge;
    logic [SB:0]      trial_sub;

    // Emit-step signals
    logic              n_armed;
    logic              drive;
    bssc_pkg::t_phase  ph_pwm;
    bssc_pkg::t_phase  ph_low;
    logic              a_on;
    logic              b_on;
    logic              c_on;
    logic [DB-1:0]     a_duty;
    logic [DB-1:0]     b_duty;
    logic [DB-1:0]     c_duty;

    // Output register
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_valid;

    // ---------------- sequencer ----------------
    assign uw       = bssc_pkg::ucode(r_step);
    assign out_free = !r_out_valid || m_tready;
    assign s_tready = (uw.wt == bssc_pkg::W_IN);

    always_comb begin
        case (uw.wt)
            bssc_pkg::W_IN:  fire = s_tvalid;
            bssc_pkg::W_OUT: fire = out_free;
            default:         fire = 1'b1;
        endcase
        if (!fire) begin
            n_step = r_step;           // hold until the handshake allows
        end else if (uw.loop && (r_cnt != '0)) begin
            n_step = r_step;           // stay in the loop
        end else begin
            n_step = uw.nxt;
        end
    end

    // ---------------- datapath terms ----------------
    // Signed differences as (SB+1)-bit two's complement
    assign diff     = {1'b0, r_sample} - {1'b0, r_pedal_idle};
    assign den      = {1'b0, r_pedal_max} - {1'b0, r_pedal_idle};
    assign diff_abs = diff[SB] ? SB'(-diff) : diff[SB-1:0];
    assign den_abs  = den[SB] ? SB'(-den) : den[SB-1:0];

    assign prod     = (SB+DB)'(r_a) * (SB+DB)'(r_duty_limit);

    // One restoring divide step: bring down the next numerator bit
    assign trial     = {r_rem, r_num[DB-1]};
    assign trial_ge  = trial >= {1'b0, r_d};
    assign trial_sub = trial - {1'b0, r_d};

    // Interlock and six-step drive
    assign n_armed = r_armed || (r_duty <= r_arm_thr);
    assign drive   = n_armed && (r_duty >= r_duty_thr) && (r_step_no != '0);
    assign ph_pwm  = bssc_pkg::pwm_phase(r_step_no);
    assign ph_low  = bssc_pkg::low_phase(r_step_no);

    assign a_on   = drive && (ph_pwm == bssc_pkg::PH_A || ph_low == bssc_pkg::PH_A);
    assign b_on   = drive && (ph_pwm == bssc_pkg::PH_B || ph_low == bssc_pkg::PH_B);
    assign c_on   = drive && (ph_pwm == bssc_pkg::PH_C || ph_low == bssc_pkg::PH_C);
    assign a_duty = (drive && ph_pwm == bssc_pkg::PH_A) ? r_duty : '0;
    assign b_duty = (drive && ph_pwm == bssc_pkg::PH_B) ? r_duty : '0;
    assign c_duty = (drive && ph_pwm == bssc_pkg::PH_C) ? r_duty : '0;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= bssc_pkg::US_FETCH;
            r_armed      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pedal_idle <= SB'(bssc_pkg::PEDAL_IDLE_RST);
            r_pedal_max  <= SB'(bssc_pkg::PEDAL_MAX_RST);
            r_duty_limit <= DB'(bssc_pkg::DUTY_LIMIT_RST);
            r_duty_thr   <= DB'(bssc_pkg::DUTY_THRESHOLD_RST);
            r_arm_thr    <= DB'(bssc_pkg::ARM_THRESHOLD_RST);
        end else begin
            r_step <= n_step;

            // Output register: load on emit, drop after the transfer
            if (fire && uw.op == bssc_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
                r_armed     <= n_armed;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (bssc_pkg::t_cfg_idx'(i_cfg_idx))
                    bssc_pkg::CFG_PEDAL_IDLE:     r_pedal_idle <= i_cfg_data[SB-1:0];
                    bssc_pkg::CFG_PEDAL_MAX:      r_pedal_max  <= i_cfg_data[SB-1:0];
                    bssc_pkg::CFG_DUTY_LIMIT:     r_duty_limit <= i_cfg_data[DB-1:0];
                    bssc_pkg::CFG_DUTY_THRESHOLD: r_duty_thr   <= i_cfg_data[DB-1:0];
                    bssc_pkg::CFG_ARM_THRESHOLD:  r_arm_thr    <= i_cfg_data[DB-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (fire) begin
            case (uw.op)
                bssc_pkg::OP_LOAD: begin
                    r_sample  <= s_tdata[HW+SB-1:HW];
                    r_step_no <= bssc_pkg::hall_step(s_tdata[HW-1:0]);
                end
                bssc_pkg::OP_DIFF: begin
                    r_a    <= diff_abs;
                    r_d    <= den_abs;
                    // Empty range, zero numerator or a negative quotient all give 0
                    r_zero <= (den == '0) || (diff == '0) || (diff[SB] != den[SB]);
                end
                bssc_pkg::OP_MUL: begin
                    // |diff| >= |den| means the quotient reaches the limit
                    r_sat <= r_a >= r_d;
                    r_rem <= prod[SB+DB-1:DB];
                    r_num <= prod[DB-1:0];
                    r_cnt <= CNT_W'(DB - 1);
                end
                bssc_pkg::OP_DIV: begin
                    r_rem <= trial_ge ? trial_sub[SB-1:0] : trial[SB-1:0];
                    r_num <= {r_num[DB-2:0], 1'b0};
                    r_q   <= {r_q[DB-2:0], trial_ge};
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                bssc_pkg::OP_CLAMP: begin
                    if (r_zero) begin
                        r_duty <= '0;
                    end else if (r_sat) begin
                        r_duty <= r_duty_limit;
                    end else begin
                        r_duty <= r_q;
                    end
                end
                bssc_pkg::OP_EMIT: begin
                    r_out_data <= OUT_W'({n_armed, r_duty, r_step_no,
                                          c_duty, c_on, b_duty, b_on, a_duty, a_on});
                end
                default: ;
            endcase
        end
    end

    assign m_tdata  = r_out_data;
    assign m_tvalid = r_out_valid;

endmodule

// ----- rtl/bssc_checker.sv -----
module bssc_checker #(
    parameter int SAMPLE_BITS = bssc_pkg::SAMPLE_BITS_DEF,
    parameter int DUTY_BITS   = bssc_pkg::DUTY_BITS_DEF,
    localparam int OUT_W = ((4 * DUTY_BITS + 7 + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              m_tvalid,
    input logic              m_tready
);

    localparam int DB = DUTY_BITS;

    logic          a_on;
    logic          b_on;
    logic          c_on;
    logic [DB-1:0] a_duty;
    logic [DB-1:0] b_duty;
    logic [DB-1:0] c_duty;
    logic [2:0]    step_no;

    assign a_on    = m_tdata[0];
    assign a_duty  = m_tdata[DB:1];
    assign b_on    = m_tdata[DB+1];
    assign b_duty  = m_tdata[2*DB+1:DB+2];
    assign c_on    = m_tdata[2*DB+2];
    assign c_duty  = m_tdata[3*DB+2:2*DB+3];
    assign step_no = m_tdata[3*DB+5:3*DB+3];

    // One item at a time: no input transfer right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // Either all phases float or exactly two are enabled
    a_two_phases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ($countones({a_on, b_on, c_on}) == 0 ||
                      $countones({a_on, b_on, c_on}) == 2))
        else $error("phase enable pattern is not zero or two phases");

    // A disabled phase reports zero compare
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((a_on || a_duty == '0) && (b_on || b_duty == '0) &&
                      (c_on || c_duty == '0)))
        else $error("disabled phase carries a nonzero duty");

    // Driving only for a valid step
    a_step_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (a_on || b_on || c_on)) |-> (step_no != 3'd0 && step_no != 3'd7))
        else $error("phases driven without a valid commutation step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind bldc_six_step_commutator_unit bssc_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DUTY_BITS  (DUTY_BITS)
) u_bssc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);

// ----- sim/bssc_phase_checker.sv -----
`timescale 1ns / 100ps

// Watches both streams and the register port of the commutator, predicts each
// drive word and compares it field by field with the word that comes out.
module bssc_phase_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    // Layout of m_tdata, lowest field last
    typedef struct packed {
        logic       armed;
        logic [8:0] duty;
        logic [2:0] step;
        logic [8:0] c_duty;
        logic       c_on;
        logic [8:0] b_duty;
        logic       b_on;
        logic [8:0] a_duty;
        logic       a_on;
    } t_drive_word;

    localparam int WORD_W = $bits(t_drive_word);
    localparam int N_FIELDS = 9;
    localparam int FIELD_LSB [N_FIELDS] = '{0, 1, 10, 11, 20, 21, 30, 33, 42};
    localparam int FIELD_W   [N_FIELDS] = '{1, 9, 1, 9, 1, 9, 3, 9, 1};

    // Step per hall code, code 7 in the top slot
    localparam logic [23:0] STEP_OF_HALL =
        {3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd0};

    string field_name [N_FIELDS] = '{"phase_a_on", "phase_a_duty", "phase_b_on",
        "phase_b_duty", "phase_c_on", "phase_c_duty", "step_number", "mapped_duty",
        "armed"};

    logic [11:0] idle_q;
    logic [11:0] max_q;
    logic [8:0]  limit_q;
    logic [8:0]  dthr_q;
    logic [8:0]  athr_q;
    logic        armed_q;
    t_drive_word drive_q [$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic [8:0] pedal_to_duty(input logic [11:0] pedal);
        longint num;
        longint den;
        longint q;
        num = (longint'(pedal) - longint'(idle_q)) * longint'(limit_q);
        den = longint'(max_q) - longint'(idle_q);
        if (den == 0) return '0;
        q = num / den;
        if (q < 0) q = 0;
        if (q > longint'(limit_q)) q = longint'(limit_q);
        return 9'(q);
    endfunction

    // Advance the interlock and form the drive word of one tick
    function automatic t_drive_word predict_tick(input logic [2:0] hall,
                                                 input logic [11:0] pedal);
        t_drive_word      w;
        logic [2:0]       step;
        logic [8:0]       duty;
        logic [2:0]       leg_on;
        logic [8:0]       leg_duty [3];
        bssc_pkg::t_phase hi;
        bssc_pkg::t_phase lo;
        step = STEP_OF_HALL[hall * 3 +: 3];
        duty = pedal_to_duty(pedal);
        leg_on = '0;
        leg_duty = '{default: '0};
        hi = bssc_pkg::PH_A;
        lo = bssc_pkg::PH_A;
        if (!armed_q && duty <= athr_q) armed_q = 1'b1;
        if (armed_q && duty >= dthr_q && step != 3'd0) begin
            case (step)
                3'd1: begin hi = bssc_pkg::PH_B; lo = bssc_pkg::PH_A; end
                3'd2: begin hi = bssc_pkg::PH_C; lo = bssc_pkg::PH_A; end
                3'd3: begin hi = bssc_pkg::PH_C; lo = bssc_pkg::PH_B; end
                3'd4: begin hi = bssc_pkg::PH_A; lo = bssc_pkg::PH_B; end
                3'd5: begin hi = bssc_pkg::PH_A; lo = bssc_pkg::PH_C; end
                default: begin hi = bssc_pkg::PH_B; lo = bssc_pkg::PH_C; end
            endcase
            leg_on[int'(hi)] = 1'b1;
            leg_duty[int'(hi)] = duty;
            leg_on[int'(lo)] = 1'b1;
        end
        w.a_on   = leg_on[int'(bssc_pkg::PH_A)];
        w.a_duty = leg_duty[int'(bssc_pkg::PH_A)];
        w.b_on   = leg_on[int'(bssc_pkg::PH_B)];
        w.b_duty = leg_duty[int'(bssc_pkg::PH_B)];
        w.c_on   = leg_on[int'(bssc_pkg::PH_C)];
        w.c_duty = leg_duty[int'(bssc_pkg::PH_C)];
        w.step   = step;
        w.duty   = duty;
        w.armed  = armed_q;
        return w;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_drive_word       want_w;
        logic [WORD_W-1:0] got_bits;
        logic [WORD_W-1:0] want_bits;
        int                g;
        int                e;
        if (!i_rst_n) begin
            idle_q  = 12'(bssc_pkg::PEDAL_IDLE_RST);
            max_q   = 12'(bssc_pkg::PEDAL_MAX_RST);
            limit_q = 9'(bssc_pkg::DUTY_LIMIT_RST);
            dthr_q  = 9'(bssc_pkg::DUTY_THRESHOLD_RST);
            athr_q  = 9'(bssc_pkg::ARM_THRESHOLD_RST);
            armed_q = 1'b0;
            drive_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (bssc_pkg::t_cfg_idx'(i_cfg_idx))
                    bssc_pkg::CFG_PEDAL_IDLE:     idle_q  = i_cfg_data;
                    bssc_pkg::CFG_PEDAL_MAX:      max_q   = i_cfg_data;
                    bssc_pkg::CFG_DUTY_LIMIT:     limit_q = i_cfg_data[8:0];
                    bssc_pkg::CFG_DUTY_THRESHOLD: dthr_q  = i_cfg_data[8:0];
                    bssc_pkg::CFG_ARM_THRESHOLD:  athr_q  = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(predict_tick(s_tdata[2:0], s_tdata[14:3]));
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("result without pending item", 1, 0);
                end else begin
                    want_w = drive_q.pop_front();
                    want_bits = want_w;
                    got_bits = m_tdata[WORD_W-1:0];
                    for (int i = 0; i < N_FIELDS; i++) begin
                        g = int'(got_bits >> FIELD_LSB[i]) & ((1 << FIELD_W[i]) - 1);
                        e = int'(want_bits >> FIELD_LSB[i]) & ((1 << FIELD_W[i]) - 1);
                        if (g != e) report_mismatch(field_name[i], g, e);
                    end
                end
            end
            o_pending <= drive_q.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    // Longest stretch without any transfer before the run is declared hung;
    // the longest legal one is the receiver hold-off plus one item latency.
    localparam int STALL_LIMIT  = 4000;
    // Quiet cycles after the last result, well beyond the time one item takes
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 241;
    localparam int N_PHASES     = 8;
    // Receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES  = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    // s_tdata: hall_code [2:0], pedal_sample [14:3], zero [15]
    logic [15:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // m_tdata: phase_a_on, phase_a_duty, phase_b_on, phase_b_duty, phase_c_on,
    // phase_c_duty, step_number, mapped_duty, armed, zero fill to bit 47
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_data = '0;

    int          pending;
    int          fail_count;
    int          results_seen = 0;
    int          quiet_cycles = 0;
    bit          hold_done = 1'b0;
    logic [11:0] cur_idle = 12'(bssc_pkg::PEDAL_IDLE_RST);
    logic [11:0] cur_max = 12'(bssc_pkg::PEDAL_MAX_RST);

    always #1 i_clk = ~i_clk;

    bldc_six_step_commutator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    bssc_phase_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one tick and hold it until the block takes the transfer.
    // Valid stays high across back-to-back items so it never drops and rises
    // in the same step.
    task automatic send_item(input logic [2:0] hall, input logic [11:0] pedal,
                             input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= {1'b0, pedal, hall};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drop valid, wait for every predicted word, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bssc_pkg::t_cfg_idx idx, input logic [11:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Write all five registers back to back; call only while idle
    task automatic set_regs(input logic [11:0] idle, input logic [11:0] pmax,
                            input logic [8:0] limit, input logic [8:0] dthr,
                            input logic [8:0] athr);
        write_reg(bssc_pkg::CFG_PEDAL_IDLE, idle);
        write_reg(bssc_pkg::CFG_PEDAL_MAX, pmax);
        write_reg(bssc_pkg::CFG_DUTY_LIMIT, 12'(limit));
        write_reg(bssc_pkg::CFG_DUTY_THRESHOLD, 12'(dthr));
        write_reg(bssc_pkg::CFG_ARM_THRESHOLD, 12'(athr));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_idle = idle;
        cur_max  = pmax;
    endtask

    // Watchdog and result count; reset any quiet run on a transfer or a write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) results_seen <= results_seen + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random ready runs and gaps, with one long hold-off early on
    // while the sender keeps offering ticks.
    initial begin : receiver
        int run;
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && results_seen >= 40) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            // Occasionally a long stretch with ready held high
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [11:0] ped;
        logic [11:0] near;
        logic [11:0] v;
        bit          tight;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Interlock still closed: high pedal keeps every phase off
        send_item(3'd5, 12'd4095, 1'b0);
        send_item(3'd0, 12'd3363, 1'b0);
        send_item(3'd7, 12'd2000, 1'b0);
        send_item(3'd1, 12'd1500, 1'b0);
        // Arming tick: duty drops under the arm level and drives at once
        send_item(3'd3, 12'd1400, 1'b0);
        // Just under and exactly at the drive threshold
        send_item(3'd2, 12'd1275, 1'b0);
        send_item(3'd6, 12'd1276, 1'b0);
        // Pedal below idle clamps to zero
        send_item(3'd4, 12'd0, 1'b0);
        // Invalid hall codes turn all phases off
        send_item(3'd0, 12'd2500, 1'b0);
        send_item(3'd7, 12'd2500, 1'b0);
        // Every valid step at full pedal, clamped to the limit
        send_item(3'd5, 12'd4095, 1'b1);
        send_item(3'd1, 12'd4095, 1'b1);
        send_item(3'd3, 12'd4095, 1'b1);
        send_item(3'd2, 12'd4095, 1'b1);
        send_item(3'd6, 12'd4095, 1'b1);
        send_item(3'd4, 12'd4095, 1'b1);

        // Full range, zero threshold: a zero duty still drives the low phase
        wait_idle();
        set_regs(12'd0, 12'd4095, 9'd511, 9'd0, 9'd0);
        send_item(3'd5, 12'd0, 1'b0);
        send_item(3'd4, 12'd4095, 1'b0);

        // Degenerate range maps everything to zero
        wait_idle();
        set_regs(12'd2048, 12'd2048, 9'd408, 9'd5, 9'd30);
        send_item(3'd1, 12'd4095, 1'b0);

        // Inverted range gives a falling map
        wait_idle();
        set_regs(12'd4095, 12'd0, 9'd511, 9'd511, 9'd511);
        send_item(3'd3, 12'd0, 1'b0);
        send_item(3'd2, 12'd4095, 1'b0);

        // Random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p)
                0: set_regs(12'(bssc_pkg::PEDAL_IDLE_RST), 12'(bssc_pkg::PEDAL_MAX_RST),
                            9'(bssc_pkg::DUTY_LIMIT_RST),
                            9'(bssc_pkg::DUTY_THRESHOLD_RST),
                            9'(bssc_pkg::ARM_THRESHOLD_RST));
                1: set_regs(12'd0, 12'd4095, 9'd511, 9'd0, 9'd0);
                2: begin
                    v = 12'($urandom_range(0, 4095));
                    set_regs(v, v, 9'($urandom_range(0, 511)), 9'd0, 9'd0);
                end
                3: set_regs(12'd4095, 12'd0, 9'($urandom_range(0, 511)),
                            9'($urandom_range(0, 40)), 9'd511);
                4: set_regs(12'd1000, 12'd3000, 9'd0, 9'd0, 9'd0);
                5: set_regs(12'd0, 12'd4095, 9'd511, 9'd511, 9'd0);
                default: set_regs(12'($urandom_range(0, 4095)),
                                  12'($urandom_range(0, 4095)),
                                  9'($urandom_range(0, 511)),
                                  9'($urandom_range(0, 40)),
                                  9'($urandom_range(0, 511)));
            endcase
            // Some phases run with the sender never idling
            tight = (p % 3) == 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    ped = 12'($urandom_range(0, 4095));
                end else begin
                    // Land near an end of the mapped range; wrap is harmless
                    near = $urandom_range(0, 1) ? cur_idle : cur_max;
                    ped = near + 12'($urandom_range(0, 8)) - 12'd4;
                end
                send_item(3'($urandom_range(0, 7)), ped, tight);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bssc_pkg.sv
rtl/bldc_six_step_commutator_unit.sv
rtl/bssc_checker.sv
sim/bssc_phase_checker.sv
sim/tb_top.sv
